// File: rtl/rtphp_pkg.sv
// ----------------------------------------------------------------------------
// rtphp_pkg
// shared constants, result codes and transfer structs of the rtp header parser
// ----------------------------------------------------------------------------
package rtphp_pkg;

    localparam int MAX_BYTES     = 65535;
    localparam int MAX_CSRC      = 15;
    localparam int FIXED_LEN     = 12;
    localparam int EXT_HDR_BYTES = 4;
    localparam int RTP_VERSION   = 2;
    localparam int CSRC_IDX_W    = $clog2(MAX_CSRC + 1);
    localparam int OFF_W         = 19;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_CSRC   = 2'd1,
        KIND_LAYOUT = 2'd2
    } rtphp_kind_t;

    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_SHORT     = 3'd1,
        STATUS_VERSION   = 3'd2,
        STATUS_CSRC_TRNC = 3'd3,
        STATUS_EXT_HDR   = 3'd4,
        STATUS_EXT_DATA  = 3'd5,
        STATUS_PADDING   = 3'd6,
        STATUS_OVERSIZE  = 3'd7
    } rtphp_status_t;

    // header fields of a datagram as they stand after its final byte
    typedef struct packed {
        logic [7:0]  hdr0;
        logic [7:0]  hdr1;
        logic [15:0] seq;
        logic [31:0] timestamp;
        logic [31:0] ssrc;
        logic [15:0] ext_profile;
        logic [15:0] ext_words;
        logic [15:0] len;
        logic [7:0]  last_byte;
        logic        oversize;
        logic        bank;
    } rtphp_snap_t;

    typedef struct packed {
        logic                  en;
        logic                  bank;
        logic [CSRC_IDX_W-1:0] idx;
        logic [31:0]           data;
    } rtphp_csrc_wr_t;

endpackage

// File: rtl/rtp_header_parser_top.sv
// ----------------------------------------------------------------------------
// rtp_header_parser_top
// rtp fixed header, csrc list and extension header parser
// ----------------------------------------------------------------------------
// Datagram bytes are taken one per clock while s_ready is high. Header
// fields are captured as they pass; CSRC words go to a two-bank memory so a
// new datagram can be received while the results of the previous one are
// read out. After the final byte is accepted the emitter runs the check
// states CHK1 and CHK2, then loads the first result into the output
// register; the rest follow one per cycle while m_ready is high: cc + 2
// results for a good datagram, one status result otherwise. The final byte
// of a datagram is held off (s_ready low) while the previous datagram's
// checks and results are still in progress, until its last result is loaded.
module rtp_header_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_datagram,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [2:0]  m_status,
    output logic        m_marker_bit,
    output logic [6:0]  m_payload_type,
    output logic [15:0] m_sequence_number,
    output logic [31:0] m_word_a,
    output logic [31:0] m_word_b,
    output logic [15:0] m_payload_offset,
    output logic [15:0] m_payload_length,
    output logic [7:0]  m_padding_size,
    output logic        m_extension_present,
    output logic        m_last_of_run
);

    rtphp_pkg::rtphp_snap_t    snap;
    rtphp_pkg::rtphp_csrc_wr_t csrc_wr;
    logic                      busy;
    logic                      byte_en;
    logic                      start;

    assign s_ready = !(busy && s_end_of_datagram);
    assign byte_en = s_valid && s_ready;
    assign start   = byte_en && s_end_of_datagram;

    rtphp_capture u_capture (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .byte_en         (byte_en),
        .data_byte       (s_data_byte),
        .end_of_datagram (s_end_of_datagram),
        .snap            (snap),
        .csrc_wr         (csrc_wr)
    );

    rtphp_emit u_emit (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .start               (start),
        .snap                (snap),
        .csrc_wr             (csrc_wr),
        .busy                (busy),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_kind              (m_kind),
        .m_status            (m_status),
        .m_marker_bit        (m_marker_bit),
        .m_payload_type      (m_payload_type),
        .m_sequence_number   (m_sequence_number),
        .m_word_a            (m_word_a),
        .m_word_b            (m_word_b),
        .m_payload_offset    (m_payload_offset),
        .m_payload_length    (m_payload_length),
        .m_padding_size      (m_padding_size),
        .m_extension_present (m_extension_present),
        .m_last_of_run       (m_last_of_run)
    );

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> busy)
        else $error("emitter not busy after final byte");

    a_csrc_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == rtphp_pkg::KIND_CSRC) |-> !m_last_of_run)
        else $error("csrc transaction marked last");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != rtphp_pkg::STATUS_OK) |->
            (m_kind == rtphp_pkg::KIND_HEADER && m_last_of_run))
        else $error("status transaction not a single header result");

    a_layout_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == rtphp_pkg::KIND_LAYOUT) |-> m_last_of_run)
        else $error("layout transaction not last");

endmodule

// File: rtl/rtphp_capture.sv
// ----------------------------------------------------------------------------
// rtphp_capture
// per-byte header capture; assembles csrc words for the csrc memory
// ----------------------------------------------------------------------------
module rtphp_capture (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     byte_en,
    input  logic [7:0]               data_byte,
    input  logic                     end_of_datagram,
    output rtphp_pkg::rtphp_snap_t   snap,
    output rtphp_pkg::rtphp_csrc_wr_t csrc_wr
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic        oversize_reg, oversize_next;
    logic        bank_reg, bank_next;
    logic [7:0]  hdr0_reg, hdr0_next;
    logic [7:0]  hdr1_reg, hdr1_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] ts_reg, ts_next;
    logic [31:0] ssrc_reg, ssrc_next;
    logic [23:0] asm_reg, asm_next;
    logic [15:0] ext_profile_reg, ext_profile_next;
    logic [15:0] ext_words_reg, ext_words_next;

    logic        in_range;
    logic        cap_en;
    logic [15:0] ext_at;
    logic [15:0] csrc_pos;

    assign in_range = byte_count_reg < 16'(rtphp_pkg::MAX_BYTES);
    assign cap_en   = byte_en && in_range;
    assign ext_at   = 16'(rtphp_pkg::FIXED_LEN) + {10'd0, hdr0_reg[3:0], 2'b00};
    assign csrc_pos = byte_count_reg - 16'(rtphp_pkg::FIXED_LEN);

    always_comb begin
        hdr0_next        = hdr0_reg;
        hdr1_next        = hdr1_reg;
        seq_next         = seq_reg;
        ts_next          = ts_reg;
        ssrc_next        = ssrc_reg;
        asm_next         = asm_reg;
        ext_profile_next = ext_profile_reg;
        ext_words_next   = ext_words_reg;
        csrc_wr.en       = 1'b0;
        csrc_wr.bank     = bank_reg;
        csrc_wr.idx      = csrc_pos[5:2];
        csrc_wr.data     = {asm_reg, data_byte};
        if (cap_en) begin
            if (byte_count_reg == 16'd0) begin
                hdr0_next = data_byte;
            end else if (byte_count_reg == 16'd1) begin
                hdr1_next = data_byte;
            end else if (byte_count_reg < 16'd4) begin
                seq_next = {seq_reg[7:0], data_byte};
            end else if (byte_count_reg < 16'd8) begin
                ts_next = {ts_reg[23:0], data_byte};
            end else if (byte_count_reg < 16'(rtphp_pkg::FIXED_LEN)) begin
                ssrc_next = {ssrc_reg[23:0], data_byte};
            end else if (byte_count_reg < ext_at) begin
                asm_next = {asm_reg[15:0], data_byte};
                if (csrc_pos[1:0] == 2'b11) begin
                    csrc_wr.en = 1'b1;
                end
            end else if (hdr0_reg[4] &&
                         byte_count_reg < ext_at + 16'(rtphp_pkg::EXT_HDR_BYTES)) begin
                if (byte_count_reg < ext_at + 16'd2) begin
                    ext_profile_next = {ext_profile_reg[7:0], data_byte};
                end else begin
                    ext_words_next = {ext_words_reg[7:0], data_byte};
                end
            end
        end
    end

    always_comb begin
        byte_count_next = byte_count_reg;
        oversize_next   = oversize_reg;
        bank_next       = bank_reg;
        if (byte_en) begin
            if (end_of_datagram) begin
                byte_count_next = 16'd0;
                oversize_next   = 1'b0;
                bank_next       = ~bank_reg;
            end else if (in_range) begin
                byte_count_next = byte_count_reg + 16'd1;
            end else begin
                oversize_next = 1'b1;
            end
        end
    end

    always_comb begin
        snap.hdr0        = hdr0_next;
        snap.hdr1        = hdr1_next;
        snap.seq         = seq_next;
        snap.timestamp   = ts_next;
        snap.ssrc        = ssrc_next;
        snap.ext_profile = ext_profile_next;
        snap.ext_words   = ext_words_next;
        snap.len         = in_range ? byte_count_reg + 16'd1 : byte_count_reg;
        snap.last_byte   = data_byte;
        snap.oversize    = oversize_reg || !in_range;
        snap.bank        = bank_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= 16'd0;
            oversize_reg   <= 1'b0;
            bank_reg       <= 1'b0;
            hdr0_reg       <= 8'd0;
        end else begin
            byte_count_reg <= byte_count_next;
            oversize_reg   <= oversize_next;
            bank_reg       <= bank_next;
            hdr0_reg       <= hdr0_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr1_reg        <= hdr1_next;
        seq_reg         <= seq_next;
        ts_reg          <= ts_next;
        ssrc_reg        <= ssrc_next;
        asm_reg         <= asm_next;
        ext_profile_reg <= ext_profile_next;
        ext_words_reg   <= ext_words_next;
    end

endmodule

// File: rtl/rtphp_emit.sv
// ----------------------------------------------------------------------------
// rtphp_emit
// datagram validation, two-bank csrc memory and result sequencing
// ----------------------------------------------------------------------------
module rtphp_emit (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  rtphp_pkg::rtphp_snap_t    snap,
    input  rtphp_pkg::rtphp_csrc_wr_t csrc_wr,
    output logic                      busy,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_kind,
    output logic [2:0]                m_status,
    output logic                      m_marker_bit,
    output logic [6:0]                m_payload_type,
    output logic [15:0]               m_sequence_number,
    output logic [31:0]               m_word_a,
    output logic [31:0]               m_word_b,
    output logic [15:0]               m_payload_offset,
    output logic [15:0]               m_payload_length,
    output logic [7:0]                m_padding_size,
    output logic                      m_extension_present,
    output logic                      m_last_of_run
);

    localparam int IW = rtphp_pkg::CSRC_IDX_W;
    localparam int OW = rtphp_pkg::OFF_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHK1,
        ST_CHK2,
        ST_HDR,
        ST_CSRC,
        ST_LAYOUT
    } state_t;

    typedef struct packed {
        rtphp_pkg::rtphp_kind_t   kind;
        rtphp_pkg::rtphp_status_t status;
        logic                     marker;
        logic [6:0]               ptype;
        logic [15:0]              seq;
        logic [31:0]              word_a;
        logic [31:0]              word_b;
        logic [15:0]              offset;
        logic [15:0]              length;
        logic [7:0]               pad;
        logic                     ext;
        logic                     last;
    } res_t;

    logic [31:0] csrc_mem [2**(IW+1)];
    logic [31:0] rdata_reg;

    state_t                   state_reg;
    rtphp_pkg::rtphp_snap_t   snap_reg;
    rtphp_pkg::rtphp_status_t status_reg, status1, status2;
    logic [OW-1:0]            off_reg;
    logic [15:0]              plen_reg;
    logic [IW-1:0]            idx_reg, idx_next;
    res_t                     res_reg, res_new;
    logic                     res_valid_reg;

    logic [3:0]    cc;
    logic          ext, padf;
    logic [OW-1:0] len_w, off_a, off_b, pad_end;
    logic [7:0]    pad_val;
    logic          out_free, load;

    assign cc      = snap_reg.hdr0[3:0];
    assign ext     = snap_reg.hdr0[4];
    assign padf    = snap_reg.hdr0[5];
    assign len_w   = OW'(snap_reg.len);
    assign off_a   = OW'(rtphp_pkg::FIXED_LEN) + OW'({cc, 2'b00});
    assign off_b   = off_a + (ext ? OW'(rtphp_pkg::EXT_HDR_BYTES) +
                                    OW'({snap_reg.ext_words, 2'b00}) : '0);
    assign pad_val = padf ? snap_reg.last_byte : 8'd0;
    assign pad_end = off_reg + OW'(pad_val);

    assign out_free = !res_valid_reg || m_ready;
    assign load     = out_free &&
                      (state_reg == ST_HDR || state_reg == ST_CSRC || state_reg == ST_LAYOUT);
    assign busy     = state_reg != ST_IDLE;

    always_comb begin
        if (snap_reg.oversize) begin
            status1 = rtphp_pkg::STATUS_OVERSIZE;
        end else if (len_w < OW'(rtphp_pkg::FIXED_LEN)) begin
            status1 = rtphp_pkg::STATUS_SHORT;
        end else if (snap_reg.hdr0[7:6] != 2'(rtphp_pkg::RTP_VERSION)) begin
            status1 = rtphp_pkg::STATUS_VERSION;
        end else if (len_w < off_a) begin
            status1 = rtphp_pkg::STATUS_CSRC_TRNC;
        end else if (ext && len_w < off_a + OW'(rtphp_pkg::EXT_HDR_BYTES)) begin
            status1 = rtphp_pkg::STATUS_EXT_HDR;
        end else begin
            status1 = rtphp_pkg::STATUS_OK;
        end
    end

    always_comb begin
        if (status_reg != rtphp_pkg::STATUS_OK) begin
            status2 = status_reg;
        end else if (ext && off_reg > len_w) begin
            status2 = rtphp_pkg::STATUS_EXT_DATA;
        end else if (padf && (pad_val == 8'd0 || pad_end > len_w)) begin
            status2 = rtphp_pkg::STATUS_PADDING;
        end else begin
            status2 = rtphp_pkg::STATUS_OK;
        end
    end

    always_comb begin
        if (state_reg == ST_CHK1) begin
            idx_next = '0;
        end else if (state_reg == ST_CSRC && out_free && idx_reg != cc - 4'd1) begin
            idx_next = idx_reg + IW'(1);
        end else begin
            idx_next = idx_reg;
        end
    end

    always_comb begin
        res_new = '0;
        case (state_reg)
            ST_HDR: begin
                res_new.kind   = rtphp_pkg::KIND_HEADER;
                res_new.status = status_reg;
                if (status_reg != rtphp_pkg::STATUS_OK) begin
                    res_new.last = 1'b1;
                end else begin
                    res_new.marker = snap_reg.hdr1[7];
                    res_new.ptype  = snap_reg.hdr1[6:0];
                    res_new.seq    = snap_reg.seq;
                    res_new.word_a = snap_reg.timestamp;
                    res_new.word_b = snap_reg.ssrc;
                    res_new.ext    = ext;
                end
            end
            ST_CSRC: begin
                res_new.kind   = rtphp_pkg::KIND_CSRC;
                res_new.word_a = rdata_reg;
                res_new.word_b = 32'(idx_reg);
            end
            ST_LAYOUT: begin
                res_new.kind   = rtphp_pkg::KIND_LAYOUT;
                res_new.word_a = ext ? {16'd0, snap_reg.ext_profile} : 32'd0;
                res_new.word_b = ext ? {16'd0, snap_reg.ext_words} : 32'd0;
                res_new.offset = off_reg[15:0];
                res_new.length = plen_reg;
                res_new.pad    = pad_val;
                res_new.ext    = ext;
                res_new.last   = 1'b1;
            end
            default: begin
                res_new = '0;
            end
        endcase
    end

    // two banks: the next datagram fills one while the other is read out
    always_ff @(posedge aclk) begin
        if (csrc_wr.en) begin
            csrc_mem[{csrc_wr.bank, csrc_wr.idx}] <= csrc_wr.data;
        end
        rdata_reg <= csrc_mem[{snap_reg.bank, idx_next}];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end else begin
            if (res_valid_reg && m_ready) begin
                res_valid_reg <= 1'b0;
            end
            if (load) begin
                res_reg       <= res_new;
                res_valid_reg <= 1'b1;
            end
            idx_reg <= idx_next;
            unique case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        snap_reg  <= snap;
                        state_reg <= ST_CHK1;
                    end
                end
                ST_CHK1: begin
                    status_reg <= status1;
                    off_reg    <= off_b;
                    state_reg  <= ST_CHK2;
                end
                ST_CHK2: begin
                    status_reg <= status2;
                    plen_reg   <= 16'(len_w - pad_end);
                    state_reg  <= ST_HDR;
                end
                ST_HDR: begin
                    if (out_free) begin
                        if (status_reg != rtphp_pkg::STATUS_OK) begin
                            state_reg <= ST_IDLE;
                        end else if (cc != 4'd0) begin
                            state_reg <= ST_CSRC;
                        end else begin
                            state_reg <= ST_LAYOUT;
                        end
                    end
                end
                ST_CSRC: begin
                    if (out_free && idx_reg == cc - 4'd1) begin
                        state_reg <= ST_LAYOUT;
                    end
                end
                ST_LAYOUT: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid             = res_valid_reg;
    assign m_kind              = res_reg.kind;
    assign m_status            = res_reg.status;
    assign m_marker_bit        = res_reg.marker;
    assign m_payload_type      = res_reg.ptype;
    assign m_sequence_number   = res_reg.seq;
    assign m_word_a            = res_reg.word_a;
    assign m_word_b            = res_reg.word_b;
    assign m_payload_offset    = res_reg.offset;
    assign m_payload_length    = res_reg.length;
    assign m_padding_size      = res_reg.pad;
    assign m_extension_present = res_reg.ext;
    assign m_last_of_run       = res_reg.last;

endmodule
